/* hw/rtl/assert_macros.svh */
// Shared assertion macros for the frame unpacker checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When pre holds at a clock edge, post holds at the same edge.
`define AFCU_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("afcu assertion failed");

// When pre holds at a clock edge, post holds at the following edge.
`define AFCU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("afcu assertion failed");

`endif

/* hw/rtl/afcu_pkg.sv */
package afcu_pkg;

    // Frame geometry.
    localparam int NUM_CHANNELS = 4;
    localparam int MAX_BYTES_PER_WORD = 4;
    localparam int POS_W = $clog2((NUM_CHANNELS + 2) * MAX_BYTES_PER_WORD + 1);
    localparam int WIDX_W = $clog2(NUM_CHANNELS + 2);
    localparam int PROD_W = POS_W + 6;

    // Queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // Configuration port.
    localparam int CFG_DATA_W = 8;

    // CRC constants.
    localparam logic [15:0] POLY_CCITT = 16'h1021;
    localparam logic [15:0] POLY_ANSI = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_TOP = 16'h8000;

    typedef enum logic [1:0] {
        CFG_WORD_FORMAT = 2'd0,
        CFG_CRC_ENABLE  = 2'd1,
        CFG_CRC_ANSI    = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        FMT_16      = 2'd0,
        FMT_24      = 2'd1,
        FMT_32_PAD  = 2'd2,
        FMT_32_SIGN = 2'd3
    } t_word_format;

    typedef enum logic [1:0] {
        KIND_STATUS    = 2'd0,
        KIND_SAMPLE    = 2'd1,
        KIND_FRAME_END = 2'd2
    } t_word_kind;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        t_word_kind         word_kind;
        logic [2:0]         channel_index;
        logic signed [31:0] sample_value;
        logic [15:0]        status_value;
        logic [15:0]        rx_crc;
        logic               crc_ok;
        logic               frame_end;
    } t_out_item;

    // One finished word as handed from the parser to the output stage.
    typedef struct packed {
        t_word_kind   kind;
        logic [2:0]   chan;
        logic [31:0]  acc;
        t_word_format fmt;
        logic         crc_en;
        logic [15:0]  crc;
        logic [15:0]  status;
    } t_word_rec;

    typedef struct packed {
        logic [WIDX_W-1:0] widx;
        logic [1:0]        bidx;
    } t_pos_split;

    // Bytes in one frame for a word format.
    function automatic logic [POS_W-1:0] frame_len(t_word_format fmt);
        logic [POS_W-1:0] len;
        case (fmt)
            FMT_16:  len = POS_W'((NUM_CHANNELS + 2) * 2);
            FMT_24:  len = POS_W'((NUM_CHANNELS + 2) * 3);
            default: len = POS_W'((NUM_CHANNELS + 2) * 4);
        endcase
        return len;
    endfunction

    // Index of the last byte within a word.
    function automatic logic [1:0] last_bidx(t_word_format fmt);
        logic [1:0] idx;
        case (fmt)
            FMT_16:  idx = 2'd1;
            FMT_24:  idx = 2'd2;
            default: idx = 2'd3;
        endcase
        return idx;
    endfunction

    // Splits a frame position into word and byte index. The divide by three
    // is a multiply by 43/128, exact for positions below 128.
    function automatic t_pos_split pos_split(logic [POS_W-1:0] pos, t_word_format fmt);
        logic [PROD_W-1:0] prod;
        logic [POS_W-1:0]  q;
        logic [POS_W-1:0]  r;
        t_pos_split        s;
        prod = '0;
        case (fmt)
            FMT_16: begin
                q = pos >> 1;
                r = pos & POS_W'(1);
            end
            FMT_24: begin
                prod = PROD_W'(pos) * PROD_W'(43);
                q = POS_W'(prod >> 7);
                r = pos - POS_W'(q * POS_W'(3));
            end
            default: begin
                q = pos >> 2;
                r = pos & POS_W'(3);
            end
        endcase
        s.widx = WIDX_W'(q);
        s.bidx = r[1:0];
        return s;
    endfunction

    // First two bytes of a word that has been shifted in most significant first.
    function automatic logic [15:0] top_field(logic [31:0] acc, t_word_format fmt);
        logic [15:0] f;
        case (fmt)
            FMT_16:  f = acc[15:0];
            FMT_24:  f = acc[23:8];
            default: f = acc[31:16];
        endcase
        return f;
    endfunction

    // Eight CRC-16 steps, most significant data bit first.
    function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b,
                                             logic [15:0] poly);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = b[i] ^ ((c & CRC_TOP) != 16'd0);
            c = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

endpackage

/* hw/rtl/afcu_front.sv */
module afcu_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  afcu_pkg::t_in_item   i_item,
    input  afcu_pkg::t_word_format i_word_format,
    input  logic                 i_crc_enable,
    input  logic                 i_crc_ansi,
    output logic                 o_rec_push,
    output afcu_pkg::t_word_rec  o_rec
);

    logic [afcu_pkg::POS_W-1:0] r_pos;
    logic [afcu_pkg::POS_W-1:0] n_pos;
    logic [15:0]                r_crc;
    logic [15:0]                n_crc;
    logic [31:0]                r_acc;
    logic [31:0]                n_acc;
    logic [15:0]                r_status;
    logic [15:0]                n_status;

    logic                       restart;
    logic [afcu_pkg::POS_W-1:0] pos;
    logic [15:0]                crc_base;
    logic [15:0]                poly;
    afcu_pkg::t_pos_split       split;
    logic                       last_byte;
    logic                       crc_word;
    logic [afcu_pkg::POS_W-1:0] pos_inc;
    afcu_pkg::t_word_kind       kind;
    logic [afcu_pkg::WIDX_W-1:0] chan_w;

    // Locate this byte in the frame, restarting on a start flag or an overrun.
    always_comb begin
        restart  = i_item.frame_start || (r_pos >= afcu_pkg::frame_len(i_word_format));
        pos      = restart ? '0 : r_pos;
        crc_base = restart ? afcu_pkg::CRC_INIT : r_crc;
        poly     = i_crc_ansi ? afcu_pkg::POLY_ANSI : afcu_pkg::POLY_CCITT;
        split    = afcu_pkg::pos_split(pos, i_word_format);
        last_byte = (split.bidx == afcu_pkg::last_bidx(i_word_format));
        crc_word = (split.widx > afcu_pkg::WIDX_W'(afcu_pkg::NUM_CHANNELS));
        pos_inc  = pos + afcu_pkg::POS_W'(1);
        chan_w   = split.widx - afcu_pkg::WIDX_W'(1);
    end

    // Word classification.
    always_comb begin
        if (split.widx == '0) begin
            kind = afcu_pkg::KIND_STATUS;
        end else if (!crc_word) begin
            kind = afcu_pkg::KIND_SAMPLE;
        end else begin
            kind = afcu_pkg::KIND_FRAME_END;
        end
    end

    // Next state: accumulator, CRC, status and position.
    always_comb begin
        n_acc = (split.bidx == 2'd0) ? {24'd0, i_item.rx_byte}
                                     : {r_acc[23:0], i_item.rx_byte};
        n_crc = crc_word ? crc_base
                         : afcu_pkg::crc_byte(crc_base, i_item.rx_byte, poly);
        n_status = r_status;
        n_pos = pos_inc;
        if (last_byte && kind == afcu_pkg::KIND_STATUS) begin
            n_status = afcu_pkg::top_field(n_acc, i_word_format);
        end
        if (last_byte && crc_word) begin
            n_pos = '0;
            n_crc = afcu_pkg::CRC_INIT;
        end
    end

    // Word record for the output stage.
    always_comb begin
        o_rec.kind   = kind;
        o_rec.chan   = (kind == afcu_pkg::KIND_SAMPLE) ? 3'(chan_w) : 3'd0;
        o_rec.acc    = n_acc;
        o_rec.fmt    = i_word_format;
        o_rec.crc_en = i_crc_enable;
        o_rec.crc    = crc_base;
        o_rec.status = n_status;
        o_rec_push   = i_accept && last_byte;
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= afcu_pkg::CRC_INIT;
            r_acc    <= '0;
            r_status <= '0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_acc    <= n_acc;
            r_status <= n_status;
        end
    end

endmodule

/* hw/rtl/afcu_queue.sv */
module afcu_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  afcu_pkg::t_word_rec i_rec,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output afcu_pkg::t_word_rec o_rec
);

    afcu_pkg::t_word_rec          r_mem [afcu_pkg::QUEUE_DEPTH];
    logic [afcu_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [afcu_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [afcu_pkg::QPTR_W:0]    r_count;
    logic                         do_push;
    logic                         do_pop;

    // Status flags and the head entry.
    always_comb begin
        o_full  = (r_count == (afcu_pkg::QPTR_W + 1)'(afcu_pkg::QUEUE_DEPTH));
        o_empty = (r_count == '0);
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_rec   = r_mem[r_rd_ptr];
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + afcu_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + afcu_pkg::QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (afcu_pkg::QPTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (afcu_pkg::QPTR_W + 1)'(1);
            end
        end
    end

endmodule

/* hw/rtl/afcu_back.sv */
module afcu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  afcu_pkg::t_word_rec i_rec,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_valid,
    output afcu_pkg::t_out_item o_item
);

    logic                r_valid;
    afcu_pkg::t_out_item r_item;
    afcu_pkg::t_out_item n_item;
    logic [15:0]         rcrc;
    logic signed [31:0]  sample;

    // Sign extension of the sample by word format.
    always_comb begin
        case (i_rec.fmt)
            afcu_pkg::FMT_16:     sample = {{16{i_rec.acc[15]}}, i_rec.acc[15:0]};
            afcu_pkg::FMT_24:     sample = {{8{i_rec.acc[23]}}, i_rec.acc[23:0]};
            afcu_pkg::FMT_32_PAD: sample = {{8{i_rec.acc[31]}}, i_rec.acc[31:8]};
            default:              sample = i_rec.acc;
        endcase
        rcrc = afcu_pkg::top_field(i_rec.acc, i_rec.fmt);
    end

    // Build the result item from the word record.
    always_comb begin
        n_item.word_kind     = i_rec.kind;
        n_item.channel_index = i_rec.chan;
        n_item.status_value  = i_rec.status;
        n_item.sample_value  = '0;
        n_item.rx_crc        = '0;
        n_item.crc_ok        = 1'b0;
        n_item.frame_end     = 1'b0;
        case (i_rec.kind)
            afcu_pkg::KIND_SAMPLE: begin
                n_item.sample_value = sample;
            end
            afcu_pkg::KIND_FRAME_END: begin
                n_item.rx_crc       = rcrc;
                n_item.crc_ok       = !i_rec.crc_en || (i_rec.crc == rcrc);
                n_item.frame_end    = 1'b1;
            end
            default: begin
                n_item.channel_index = '0;
            end
        endcase
    end

    // Refill the output register when it is empty or being taken.
    always_comb begin
        o_q_pop = !i_q_empty && (!r_valid || i_pop);
        o_valid = r_valid;
        o_item  = r_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= n_item;
        end
    end

endmodule

/* hw/rtl/adc_frame_crc_unpacker.sv */
// Unpacks delta-sigma ADC response frames arriving one byte per item and
// checks their CRC-16. Each frame is a status word, NUM_CHANNELS sample
// words and a CRC word; one result item leaves on the last byte of every
// word. A byte is taken every clock cycle while the queue is not full: the
// parser settles position, word assembly and the unrolled 8-bit CRC step
// combinationally, and finished words pass through a four-entry queue into
// an output register. push is refused (full high) only while the queue is
// full, which happens once five results wait unpopped: four in the queue
// and one on the result ports. A finished word is written into the queue,
// and from there into the output register that drives the result ports.
// Configuration writes are always taken (ready held high) and should be
// issued only while no frame byte is in flight.
module adc_frame_crc_unpacker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  afcu_pkg::t_in_item          i_in_item,
    output logic                        empty,
    input  logic                        pop,
    output afcu_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [afcu_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    afcu_pkg::t_word_format r_word_format;
    logic                   r_crc_enable;
    logic                   r_crc_ansi;

    logic                   accept;
    logic                   rec_push;
    afcu_pkg::t_word_rec    front_rec;
    afcu_pkg::t_word_rec    head_rec;
    logic                   q_empty;
    logic                   q_pop;
    logic                   out_valid;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_format <= afcu_pkg::FMT_24;
            r_crc_enable  <= 1'b0;
            r_crc_ansi    <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (afcu_pkg::t_cfg_index'(i_cfg_index))
                afcu_pkg::CFG_WORD_FORMAT: begin
                    r_word_format <= afcu_pkg::t_word_format'(i_cfg_data[1:0]);
                end
                afcu_pkg::CFG_CRC_ENABLE: begin
                    r_crc_enable <= i_cfg_data[0];
                end
                afcu_pkg::CFG_CRC_ANSI: begin
                    r_crc_ansi <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input handshake.
    assign accept = push && !full;
    assign empty  = !out_valid;

    afcu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_in_item),
        .i_word_format (r_word_format),
        .i_crc_enable  (r_crc_enable),
        .i_crc_ansi    (r_crc_ansi),
        .o_rec_push    (rec_push),
        .o_rec         (front_rec)
    );

    afcu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_rec   (front_rec),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rec   (head_rec)
    );

    afcu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_rec     (head_rec),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_valid   (out_valid),
        .o_item    (o_out_item)
    );

endmodule

/* hw/rtl/afcu_checker.sv */
`include "assert_macros.svh"

module afcu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        empty,
    input logic                        pop,
    input afcu_pkg::t_out_item         o_out_item
);

    logic end_kind;
    logic sample_kind;
    logic sample_clear;
    logic crc_clear;

    // Decoded views of the result on the ports.
    always_comb begin
        end_kind     = (o_out_item.word_kind == afcu_pkg::KIND_FRAME_END);
        sample_kind  = (o_out_item.word_kind == afcu_pkg::KIND_SAMPLE);
        sample_clear = (o_out_item.sample_value == 32'sd0)
                    && (o_out_item.channel_index == 3'd0);
        crc_clear    = !o_out_item.crc_ok && (o_out_item.rx_crc == 16'd0);
    end

    // Frame end is flagged exactly on frame end items.
    `AFCU_ASSERT_SAME(a_frame_end_kind, i_clk, i_rst_n, !empty, o_out_item.frame_end == end_kind)

    // Only sample items carry a sample value or channel number.
    `AFCU_ASSERT_SAME(a_sample_only, i_clk, i_rst_n, !empty && !sample_kind, sample_clear)

    // A CRC pass or a received CRC is only reported at frame end.
    `AFCU_ASSERT_SAME(a_crc_only_at_end, i_clk, i_rst_n, !empty && !o_out_item.frame_end, crc_clear)

    // A result that is not popped stays on the ports.
    `AFCU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_out_item))

endmodule

bind adc_frame_crc_unpacker afcu_checker u_afcu_checker (.*);
